### sv/nls_pkg.sv
// Package for the numeric literal scanner: item and result types,
// character constants, pending codes and character class helpers. No dependencies.
package nls_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       final_req;
  } nls_in_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] token_length;
    logic [7:0] point_pos;
    logic [7:0] exp_pos;
    logic       too_long;
  } nls_out_t;

  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharPoint      = 8'h2E;
  localparam logic [7:0] CharPlus       = 8'h2B;
  localparam logic [7:0] CharMinus      = 8'h2D;

  // what is held waiting for the next character
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendPoint = 2'd1;
  localparam logic [1:0] PendSign  = 2'd2;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_lower(c) || is_upper(c);
  endfunction

endpackage

### sv/nls_core.sv
// Scan state registers and the per-character next-state logic.
// Depends on nls_pkg.
module nls_core import nls_pkg::*; #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  nls_in_t  item_i,
  output logic     res_valid_o,
  output nls_out_t res_o
);

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam int unsigned EXT_W = (POS_W > 8) ? POS_W : 8;
  localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_LEN);

  logic             scanning_q, scanning_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             seen_point_q, seen_point_d;
  logic             seen_sign_q, seen_sign_d;
  logic             seen_exp_q, seen_exp_d;
  logic [POS_W-1:0] point_idx_q, point_idx_d;
  logic [POS_W-1:0] exp_idx_q, exp_idx_d;
  logic [1:0]       pend_q, pend_d;

  always_comb begin
    logic             do_consume;
    logic             do_hold;
    logic [1:0]       hold_kind;
    logic             do_finish;
    logic             no_lit;
    logic [POS_W-1:0] fin_len;
    logic             fin_cut;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] pp_len;
    logic [POS_W-1:0] ex_len;
    logic [EXT_W-1:0] len_ext;
    logic [EXT_W-1:0] pp_ext;
    logic [EXT_W-1:0] ex_ext;

    scanning_d   = scanning_q;
    pos_d        = pos_q;
    seen_point_d = seen_point_q;
    seen_sign_d  = seen_sign_q;
    seen_exp_d   = seen_exp_q;
    point_idx_d  = point_idx_q;
    exp_idx_d    = exp_idx_q;
    pend_d       = pend_q;
    do_consume   = 1'b0;
    do_hold      = 1'b0;
    hold_kind    = PendNone;
    do_finish    = 1'b0;
    no_lit       = 1'b0;
    fin_len      = '0;
    fin_cut      = 1'b0;
    p            = pos_q;

    if (fire_i) begin
      if (item_i.first) begin
        scanning_d   = 1'b0;
        pos_d        = '0;
        seen_point_d = 1'b0;
        seen_sign_d  = 1'b0;
        seen_exp_d   = 1'b0;
        point_idx_d  = '0;
        exp_idx_d    = '0;
        pend_d       = PendNone;
        if (!is_digit(item_i.ch)) begin
          no_lit = 1'b1;
        end else begin
          scanning_d = 1'b1;
          pos_d      = POS_W'(1);
          if (item_i.final_req) begin
            do_finish = 1'b1;
            fin_len   = POS_W'(1);
          end
        end
      end else if (scanning_q) begin
        if (pend_q != PendNone) begin
          if (!is_alnum(item_i.ch)) begin
            do_finish = 1'b1;
            fin_len   = p - POS_W'(1);
          end else begin
            if (pend_q == PendPoint) begin
              point_idx_d  = p - POS_W'(1);
              seen_point_d = 1'b1;
            end else begin
              seen_sign_d = 1'b1;
            end
            pend_d     = PendNone;
            do_consume = 1'b1;
          end
        end else if (is_alnum(item_i.ch) || item_i.ch == CharUnderscore) begin
          do_consume = 1'b1;
        end else if (item_i.ch == CharPoint && !seen_point_q) begin
          do_hold   = 1'b1;
          hold_kind = PendPoint;
        end else if ((item_i.ch == CharPlus || item_i.ch == CharMinus) && seen_exp_q &&
                     !seen_sign_q &&
                     ({1'b0, exp_idx_q} + (POS_W+1)'(1)) == {1'b0, p}) begin
          do_hold   = 1'b1;
          hold_kind = PendSign;
        end else begin
          do_finish = 1'b1;
          fin_len   = p;
        end

        if (do_consume) begin
          if (p >= MaxPos) begin
            do_finish = 1'b1;
            fin_len   = MaxPos;
            fin_cut   = 1'b1;
          end else begin
            // lowercase after the point and before any sign marks the exponent
            if (is_lower(item_i.ch) && seen_point_d && !seen_sign_d) begin
              exp_idx_d  = p;
              seen_exp_d = 1'b1;
            end
            pos_d = p + POS_W'(1);
            if (item_i.final_req) begin
              do_finish = 1'b1;
              fin_len   = p + POS_W'(1);
            end
          end
        end

        if (do_hold) begin
          if (item_i.final_req) begin
            do_finish = 1'b1;
            fin_len   = p;
          end else if (p >= MaxPos) begin
            do_finish = 1'b1;
            fin_len   = MaxPos;
            fin_cut   = 1'b1;
          end else begin
            pend_d = hold_kind;
            pos_d  = p + POS_W'(1);
          end
        end
      end
    end

    if (do_finish) begin
      scanning_d = 1'b0;
      pend_d     = PendNone;
    end

    pp_len  = seen_point_d ? point_idx_d : fin_len;
    ex_len  = seen_exp_d ? exp_idx_d : fin_len;
    len_ext = EXT_W'(fin_len);
    pp_ext  = EXT_W'(pp_len);
    ex_ext  = EXT_W'(ex_len);

    res_valid_o = do_finish || no_lit;
    res_o       = '0;
    if (do_finish) begin
      res_o.matched      = 1'b1;
      res_o.token_length = len_ext[7:0];
      res_o.point_pos    = pp_ext[7:0];
      res_o.exp_pos      = ex_ext[7:0];
      res_o.too_long     = fin_cut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q   <= 1'b0;
      pos_q        <= '0;
      seen_point_q <= 1'b0;
      seen_sign_q  <= 1'b0;
      seen_exp_q   <= 1'b0;
      point_idx_q  <= '0;
      exp_idx_q    <= '0;
      pend_q       <= PendNone;
    end else begin
      scanning_q   <= scanning_d;
      pos_q        <= pos_d;
      seen_point_q <= seen_point_d;
      seen_sign_q  <= seen_sign_d;
      seen_exp_q   <= seen_exp_d;
      point_idx_q  <= point_idx_d;
      exp_idx_q    <= exp_idx_d;
      pend_q       <= pend_d;
    end
  end

  a_pend_has_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning_q && pend_q != PendNone) |-> (pos_q != '0))
    else $error("pending point or sign with zero position");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("position beyond maximum length");

  a_sign_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning_q && seen_sign_q) |-> (seen_exp_q && seen_point_q))
    else $error("sign taken without point and exponent letter");

  a_exp_before_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning_q && seen_exp_q) |-> (exp_idx_q < pos_q))
    else $error("exponent index not behind current position");

  a_pend_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == PendNone || pend_q == PendPoint || pend_q == PendSign))
    else $error("illegal pending code");

endmodule

### sv/numeric_literal_scanner_unit.sv
// Numeric literal scanner top level: input register, scan core, result register.
// Depends on nls_pkg and nls_core.
//
// Takes one source character per item and reports, once per source text, the
// length of the decimal literal at its start along with point and exponent
// positions. Throughput is one item per clock unless a result waits stalled on
// the output. Results leave on out_data_o from the result register; the input
// register feeds the scan core and the result register sits behind it. The scan
// state advances only when the held item can move on, so in_stall_o rises while
// an item sits in the input register and a result waits stalled on the output.
module numeric_literal_scanner_unit import nls_pkg::*; #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nls_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nls_out_t out_data_o
);

  logic     in_valid_q, in_valid_d;
  nls_in_t  in_q;
  logic     out_valid_q, out_valid_d;
  nls_out_t out_q;
  logic     advance;
  logic     res_valid;
  nls_out_t res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  assign in_valid_d  = in_valid_i || (in_valid_q && !advance);
  assign out_valid_d = advance ? res_valid : (out_valid_q && out_stall_i);

  nls_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
